@@ rtl/assert_macros.svh @@
// Assertion macros for the serial command frame parser.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UCFP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucfp assertion failed");

// Next-cycle implication, disabled during reset.
`define UCFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucfp assertion failed");

`endif

@@ rtl/ucfp_pkg.sv @@
// Package for the serial command frame parser: sizes, codes, character
// constants, result type and the frame store reset template. No dependencies.
`default_nettype none

package ucfp_pkg;

    localparam int FRAME_BYTES   = 20;
    localparam int COMMAND_COUNT = 4;
    localparam int CMD_WORDS     = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int WORD_W        = 32;
    localparam int WIDX_W        = $clog2(FRAME_BYTES + 1);
    localparam int CMD_IDX_W     = 3;

    localparam logic [CMD_IDX_W-1:0] CMD_NO_MATCH = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CMD_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_D = 2'd3;

    localparam logic [WORD_W-1:0] CMD_A_RESET = 32'h5343_5056;
    localparam logic [WORD_W-1:0] CMD_B_RESET = 32'h4743_5056;
    localparam logic [WORD_W-1:0] CMD_C_RESET = 32'h5344_534D;
    localparam logic [WORD_W-1:0] CMD_D_RESET = 32'h4744_5354;

    localparam logic [7:0] CH_V_UP   = 8'h56;
    localparam logic [7:0] CH_V_LO   = 8'h76;
    localparam logic [7:0] CH_M_UP   = 8'h4D;
    localparam logic [7:0] CH_M_LO   = 8'h6D;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_C_UP   = 8'h43;
    localparam logic [7:0] CH_C_LO   = 8'h63;
    localparam logic [7:0] CH_L_UP   = 8'h4C;
    localparam logic [7:0] CH_L_LO   = 8'h6C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_T_UP   = 8'h54;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_OVERRUN = 2'd1,
        FAULT_START   = 2'd2
    } fault_t;

    typedef struct packed {
        logic                 verbose_on;
        logic                 celsius_on;
        logic                 lamp_on;
        logic                 receiving;
        logic                 frame_held;
        logic                 frame_done;
        logic [1:0]           error_code;
        logic [CMD_IDX_W-1:0] command_index;
        logic [31:0]          target_text;
        logic [63:0]          value_text;
    } result_t;

    // Reset image "$CCCC,TTTT,VVVVVVVV#", zero past the template.
    function automatic logic [7:0] template_byte(input int pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos == 0) ch = CH_DOLLAR;
        else if (pos >= 1 && pos <= 4) ch = CH_C_UP;
        else if (pos == 5 || pos == 10) ch = CH_COMMA;
        else if (pos >= 6 && pos <= 9) ch = CH_T_UP;
        else if (pos >= 11 && pos <= 18) ch = CH_V_UP;
        else if (pos == 19) ch = CH_HASH;
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ucfp_in_if.sv @@
// Input channel of the serial command frame parser: valid/ready plus op and
// received byte. Depends on nothing but ucfp_pkg by convention.
`default_nettype none

interface ucfp_in_if import ucfp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/ucfp_out_if.sv @@
// Result channel of the serial command frame parser: valid/ready plus status
// flags and decoded frame fields. Depends on ucfp_pkg.
`default_nettype none

interface ucfp_out_if import ucfp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 verbose_on;
    logic                 celsius_on;
    logic                 lamp_on;
    logic                 receiving;
    logic                 frame_held;
    logic                 frame_done;
    logic [1:0]           error_code;
    logic [CMD_IDX_W-1:0] command_index;
    logic [31:0]          target_text;
    logic [63:0]          value_text;

    modport source (output valid, output verbose_on, output celsius_on, output lamp_on,
                    output receiving, output frame_held, output frame_done,
                    output error_code, output command_index, output target_text,
                    output value_text, input ready);
    modport sink   (input valid, input verbose_on, input celsius_on, input lamp_on,
                    input receiving, input frame_held, input frame_done,
                    input error_code, input command_index, input target_text,
                    input value_text, output ready);
endinterface

`default_nettype wire

@@ rtl/ucfp_match.sv @@
// Command matcher: compares the four command bytes of the store against the
// command word registers. Depends on ucfp_pkg.
`default_nettype none

module ucfp_match import ucfp_pkg::*;
(
    input  wire logic [WORD_W-1:0]    cmd_text,
    input  wire logic [WORD_W-1:0]    cmd_words [CMD_WORDS],
    output logic      [CMD_IDX_W-1:0] cmd_index
);

    // Scan downward so the lowest matching word wins.
    always_comb
    begin
        cmd_index = CMD_NO_MATCH;
        for (int k = COMMAND_COUNT - 1; k >= 0; k--)
        begin
            if (cmd_words[k] == cmd_text)
            begin
                cmd_index = CMD_IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/ucfp_engine.sv @@
// Parser state and per-byte update: mode flags, frame store, write index and
// fault code; forms the result of each transfer. Depends on ucfp_pkg, ucfp_match.
`default_nettype none

module ucfp_engine import ucfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              op,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [WORD_W-1:0] cmd_words [CMD_WORDS],
    output result_t                result_next
);

    logic [7:0]        store_reg [FRAME_BYTES];
    logic [7:0]        store_next [FRAME_BYTES];
    logic [WIDX_W-1:0] widx_reg;
    logic [WIDX_W-1:0] widx_next;
    logic              collecting_reg;
    logic              collecting_next;
    logic              held_reg;
    logic              held_next;
    fault_t            fault_reg;
    fault_t            fault_next;
    logic              verbose_reg;
    logic              verbose_next;
    logic              celsius_reg;
    logic              celsius_next;
    logic              lamp_reg;
    logic              lamp_next;
    logic              done;
    logic [CMD_IDX_W-1:0] cmd_index;

    always_comb
    begin
        store_next      = store_reg;
        widx_next       = widx_reg;
        collecting_next = collecting_reg;
        held_next       = held_reg;
        fault_next      = fault_reg;
        verbose_next    = verbose_reg;
        celsius_next    = celsius_reg;
        lamp_next       = lamp_reg;
        done            = 1'b0;
        if (accept)
        begin
            if (op == OP_RELEASE)
            begin
                held_next  = 1'b0;
                fault_next = FAULT_NONE;
            end
            else if (!collecting_reg)
            begin
                case (rx_byte)
                    CH_V_UP, CH_V_LO: verbose_next = 1'b1;
                    CH_M_UP, CH_M_LO: verbose_next = 1'b0;
                    CH_F_UP, CH_F_LO: celsius_next = 1'b0;
                    CH_C_UP, CH_C_LO: celsius_next = 1'b1;
                    CH_L_UP, CH_L_LO: lamp_next    = !lamp_reg;
                    CH_DOLLAR:
                    begin
                        if (!held_reg)
                        begin
                            collecting_next = 1'b1;
                            store_next[0]   = rx_byte;
                            widx_next       = WIDX_W'(1);
                        end
                        else
                        begin
                            fault_next = FAULT_START;
                        end
                    end
                    default: ;
                endcase
            end
            else if (fault_reg == FAULT_NONE)
            begin
                for (int k = 0; k < FRAME_BYTES; k++)
                begin
                    if (widx_reg == WIDX_W'(k))
                    begin
                        store_next[k] = rx_byte;
                    end
                end
                widx_next = widx_reg + WIDX_W'(1);
                if (rx_byte == CH_HASH)
                begin
                    collecting_next = 1'b0;
                    held_next       = 1'b1;
                    done            = 1'b1;
                end
                if (widx_next >= WIDX_W'(FRAME_BYTES))
                begin
                    collecting_next = 1'b0;
                    held_next       = 1'b1;
                    fault_next      = FAULT_OVERRUN;
                    done            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRAME_BYTES; k++)
            begin
                store_reg[k] <= template_byte(k);
            end
            widx_reg       <= '0;
            collecting_reg <= 1'b0;
            held_reg       <= 1'b0;
            fault_reg      <= FAULT_NONE;
            verbose_reg    <= 1'b1;
            celsius_reg    <= 1'b0;
            lamp_reg       <= 1'b0;
        end
        else
        begin
            store_reg      <= store_next;
            widx_reg       <= widx_next;
            collecting_reg <= collecting_next;
            held_reg       <= held_next;
            fault_reg      <= fault_next;
            verbose_reg    <= verbose_next;
            celsius_reg    <= celsius_next;
            lamp_reg       <= lamp_next;
        end
    end

    ucfp_match u_match
    (
        .cmd_text  ({store_next[1], store_next[2], store_next[3], store_next[4]}),
        .cmd_words (cmd_words),
        .cmd_index (cmd_index)
    );

    always_comb
    begin
        result_next.verbose_on    = verbose_next;
        result_next.celsius_on    = celsius_next;
        result_next.lamp_on       = lamp_next;
        result_next.receiving     = collecting_next;
        result_next.frame_held    = held_next;
        result_next.frame_done    = done;
        result_next.error_code    = fault_next;
        result_next.command_index = '0;
        result_next.target_text   = '0;
        result_next.value_text    = '0;
        if (held_next)
        begin
            result_next.command_index = cmd_index;
            result_next.target_text   = {store_next[6], store_next[7],
                                         store_next[8], store_next[9]};
            result_next.value_text    = {store_next[11], store_next[12],
                                         store_next[13], store_next[14],
                                         store_next[15], store_next[16],
                                         store_next[17], store_next[18]};
        end
    end

endmodule

`default_nettype wire

@@ rtl/uart_command_frame_parser_top.sv @@
// Top level of the serial command frame parser: configuration registers,
// result register and handshake. Depends on ucfp_pkg, ucfp_in_if, ucfp_out_if,
// ucfp_engine and assert_macros.svh.
//
// One transfer on in_ch yields one result on out_ch, registered in the cycle
// after the transfer. A new byte is taken in every cycle while out_ch drains;
// the single result register sets the rate at one item per cycle and stalls
// the input only while a result waits and out_ch is not ready. The user must
// write command words via cfg_wr_en/cfg_index/cfg_data while idle; unchecked.
`default_nettype none

`include "assert_macros.svh"

module uart_command_frame_parser_top import ucfp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ucfp_in_if.sink                   in_ch,
    ucfp_out_if.source                out_ch,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0] cmd_word_reg [CMD_WORDS];
    result_t           out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;
    result_t           result_next;

    assign in_ch.ready    = !out_valid_reg || out_ch.ready;
    assign accept         = in_ch.valid && in_ch.ready;
    assign out_valid_next = accept || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_word_reg[0] <= CMD_A_RESET;
            cmd_word_reg[1] <= CMD_B_RESET;
            cmd_word_reg[2] <= CMD_C_RESET;
            cmd_word_reg[3] <= CMD_D_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CMD_A: cmd_word_reg[0] <= cfg_data;
                REG_CMD_B: cmd_word_reg[1] <= cfg_data;
                REG_CMD_C: cmd_word_reg[2] <= cfg_data;
                REG_CMD_D: cmd_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    ucfp_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (in_ch.op),
        .rx_byte     (in_ch.rx_byte),
        .cmd_words   (cmd_word_reg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register on every input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.verbose_on    = out_reg.verbose_on;
    assign out_ch.celsius_on    = out_reg.celsius_on;
    assign out_ch.lamp_on       = out_reg.lamp_on;
    assign out_ch.receiving     = out_reg.receiving;
    assign out_ch.frame_held    = out_reg.frame_held;
    assign out_ch.frame_done    = out_reg.frame_done;
    assign out_ch.error_code    = out_reg.error_code;
    assign out_ch.command_index = out_reg.command_index;
    assign out_ch.target_text   = out_reg.target_text;
    assign out_ch.value_text    = out_reg.value_text;

    `UCFP_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg)
    `UCFP_ASSERT_IMPL(a_not_held_and_receiving, out_valid_reg,
                      !(out_reg.receiving && out_reg.frame_held))
    `UCFP_ASSERT_IMPL(a_done_ends_frame, out_valid_reg && out_reg.frame_done,
                      out_reg.frame_held && !out_reg.receiving)
    `UCFP_ASSERT_IMPL(a_fields_clear_when_free, out_valid_reg && !out_reg.frame_held,
                      out_reg.command_index == '0 && out_reg.target_text == '0)

endmodule

`default_nettype wire
